@@ rtl/core/era_pkg.sv @@
// era_pkg: opcodes, unit operation codes and the shared-unit command type
// used by the rational alu core and its bit-serial arithmetic unit
`default_nettype none
package era_pkg;
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_NEG  = 3'd2;
  localparam logic [2:0] OP_NORM = 3'd3;
  localparam logic [2:0] OP_FLR  = 3'd4;
  localparam logic [2:0] OP_CEIL = 3'd5;

  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_DIV = 2'd1
  } uop_t;

  typedef struct packed {
    logic go;
    uop_t uop;
  } ucmd_t;
endpackage
`default_nettype wire

@@ rtl/core/exact_rational_alu_core.sv @@
// exact_rational_alu_core: rational add, multiply, negate, normalise,
// floor and ceiling with gcd reduction; uses era_pkg and era_unit
// run time: set by the gcd loops; each step is one bit-serial division
// on the shared unit
// throughput: one word at a time, busy high from start until out_valid
// reset: synchronous active-low rst_n clears the sequencer; no result
// is held off, each result is shown for exactly one cycle with out_valid
`default_nettype none
module exact_rational_alu_core #(
  parameter int WORD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [63:0] in_a_num,
  input  wire logic [63:0] in_a_den,
  input  wire logic        in_a_bad,
  input  wire logic [63:0] in_b_num,
  input  wire logic [62:0] in_b_den,
  input  wire logic        in_b_bad,
  output logic             out_valid,
  output logic [63:0]      out_res_num,
  output logic [62:0]      out_res_den,
  output logic             out_res_bad,
  output logic             out_is_zero,
  output logic             out_is_positive,
  output logic             out_is_negative,
  output logic             out_is_integer
);
  import era_pkg::*;
  localparam int W = WORD_BITS;
  localparam logic [W-1:0] MAXM = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINM = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DISP  = 16'h0002,
    S_MCALL = 16'h0004,
    S_MWAIT = 16'h0008,
    S_GSTEP = 16'h0010,
    S_GWAIT = 16'h0020,
    S_DCALL = 16'h0040,
    S_DWAIT = 16'h0080,
    S_NEXT  = 16'h0100,
    S_OUT   = 16'h0200,
    S_RND   = 16'h0400,
    S_RWAIT = 16'h0800
  } st_t;

  // step codes of the per-operation program
  typedef enum logic [3:0] {
    P_ADD_T1, P_ADD_T2, P_ADD_D, P_ADD_SUM,
    P_MUL_G1, P_MUL_G2, P_MUL_P, P_MUL_Q,
    P_NORM, P_RED, P_DONE
  } prog_t;

  st_t   st_r, st_nxt;
  prog_t pc_r, pc_nxt;
  logic [2:0]   op_r, op_nxt;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] an_nxt, ad_nxt, bn_nxt, bd_nxt;
  logic         asn_r, dsn_r, bsn_r, bdsn_r;
  logic         asn_nxt, dsn_nxt, bsn_nxt, bdsn_nxt;
  logic [W-1:0] t1_r, t1_nxt;
  logic         t1s_r, t1s_nxt;
  logic [W-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic [W-1:0] g1_r, g1_nxt;
  logic         bad_r, bad_nxt;
  logic         neg_r, neg_nxt;
  logic [W-1:0] mx_r, my_r, mx_nxt, my_nxt;
  logic         msgn_r, msgn_nxt;
  logic [1:0]   sub_r, sub_nxt;
  logic         ov_r, ov_nxt;
  logic [63:0]  rn_r, rn_nxt;
  logic [62:0]  rd_r, rd_nxt;
  logic         rb_r, rb_nxt, ov_valid_r, ov_valid_nxt;

  ucmd_t        ucmd;
  logic [W-1:0] ux, uy, uq, ur;
  logic         udone;

  era_unit #(.W(W)) u_unit (
    .clk(clk), .rst_n(rst_n), .cmd(ucmd), .x(ux), .y(uy),
    .done(udone), .q_lo(uq), .r_hi(ur)
  );

  function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
    f_mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [W-1:0] am_i, adm_i, bm_i;
  logic [W:0]   ssum;
  logic [W-1:0] sres;
  logic         sneg, sov;
  logic [W-1:0] lim;

  always_comb begin
    am_i  = f_mag(in_a_num[W-1:0]);
    adm_i = f_mag(in_a_den[W-1:0]);
    bm_i  = f_mag(in_b_num[W-1:0]);
    // signed add of t1 and product in mx (sign msgn) by magnitudes
    if (t1s_r == msgn_r) begin
      ssum = {1'b0, t1_r} + {1'b0, mx_r};
      sneg = t1s_r;
    end else if (t1_r >= mx_r) begin
      ssum = {1'b0, t1_r} - {1'b0, mx_r};
      sneg = t1s_r;
    end else begin
      ssum = {1'b0, mx_r} - {1'b0, t1_r};
      sneg = msgn_r;
    end
    sres = ssum[W-1:0];
    if (sres == '0) sneg = 1'b0;
    lim = sneg ? MINM : MAXM;
    sov = ssum[W] || (sres > lim);
  end

  // product limit for the multiply just finished
  logic [W-1:0] plim;
  logic         pov;
  assign plim = msgn_r ? MINM : MAXM;
  assign pov  = (ur != '0) || (uq > plim);

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; op_nxt = op_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    asn_nxt = asn_r; dsn_nxt = dsn_r; bsn_nxt = bsn_r; bdsn_nxt = bdsn_r;
    t1_nxt = t1_r; t1s_nxt = t1s_r; gx_nxt = gx_r; gy_nxt = gy_r;
    g1_nxt = g1_r; bad_nxt = bad_r; neg_nxt = neg_r;
    mx_nxt = mx_r; my_nxt = my_r; msgn_nxt = msgn_r; sub_nxt = sub_r;
    ov_nxt = ov_r; rn_nxt = rn_r; rd_nxt = rd_r; rb_nxt = rb_r;
    ov_valid_nxt = 1'b0;
    ucmd.go = 1'b0; ucmd.uop = UOP_MUL; ux = mx_r; uy = my_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_op;
          an_nxt = am_i; asn_nxt = in_a_num[W-1];
          ad_nxt = adm_i; dsn_nxt = in_a_den[W-1];
          bn_nxt = bm_i; bsn_nxt = in_b_num[W-1];
          bd_nxt = {1'b0, in_b_den[W-2:0]}; bdsn_nxt = 1'b0;
          bad_nxt = in_a_bad || ((in_op == OP_ADD || in_op == OP_MUL) && in_b_bad);
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = S_NEXT;
        case (op_r)
          OP_ADD: pc_nxt = P_ADD_T1;
          OP_MUL: pc_nxt = P_MUL_G1;
          OP_NEG: begin
            if ({asn_r, an_r} == {1'b1, MINM}) bad_nxt = 1'b1;
            if (an_r != '0) asn_nxt = ~asn_r;
            pc_nxt = P_NORM;
          end
          OP_NORM, OP_FLR, OP_CEIL: pc_nxt = P_NORM;
          default: bad_nxt = 1'b1;
        endcase
        if (bad_r) st_nxt = S_OUT;
      end
      S_NEXT: begin
        // per step: load mx/my/msgn and multiply, load gx/gy for a gcd, or fix signs
        case (pc_r)
          P_ADD_T1: begin
            mx_nxt = an_r; my_nxt = bd_r; msgn_nxt = asn_r ^ bdsn_r;
            st_nxt = S_MCALL;
          end
          P_ADD_T2: begin
            mx_nxt = bn_r; my_nxt = ad_r; msgn_nxt = bsn_r ^ dsn_r;
            st_nxt = S_MCALL;
          end
          P_ADD_D: begin
            mx_nxt = ad_r; my_nxt = bd_r; msgn_nxt = dsn_r ^ bdsn_r;
            st_nxt = S_MCALL;
          end
          P_MUL_G1: begin
            gx_nxt = an_r; gy_nxt = bd_r; sub_nxt = 2'd0; st_nxt = S_GSTEP;
          end
          P_MUL_G2: begin
            gx_nxt = bn_r; gy_nxt = ad_r; sub_nxt = 2'd0; st_nxt = S_GSTEP;
          end
          P_MUL_P: begin
            mx_nxt = an_r; my_nxt = bn_r; msgn_nxt = asn_r ^ bsn_r;
            st_nxt = S_MCALL;
          end
          P_MUL_Q: begin
            mx_nxt = ad_r; my_nxt = bd_r; msgn_nxt = dsn_r ^ bdsn_r;
            st_nxt = S_MCALL;
          end
          P_NORM: begin
            // an/asn numerator, ad/dsn denominator
            if (ad_r == '0) bad_nxt = 1'b1;
            else if (dsn_r) begin
              if ({asn_r, an_r} == {1'b1, MINM} || ad_r == MINM) bad_nxt = 1'b1;
              else begin
                dsn_nxt = 1'b0;
                if (an_r != '0) asn_nxt = ~asn_r;
              end
            end
            pc_nxt = P_RED;
          end
          P_RED: begin
            gx_nxt = an_r; gy_nxt = ad_r; sub_nxt = 2'd0; st_nxt = S_GSTEP;
          end
          default: st_nxt = S_OUT;
        endcase
        if (bad_r) st_nxt = S_OUT;
      end
      S_MCALL: begin
        ucmd.go = 1'b1; ucmd.uop = UOP_MUL; ux = mx_r; uy = my_r;
        st_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (udone) begin
          if (pov) bad_nxt = 1'b1;
          mx_nxt = uq;
          if (uq == '0) msgn_nxt = 1'b0;
          st_nxt = S_NEXT;
          case (pc_r)
            P_ADD_T1: begin
              t1_nxt = uq; t1s_nxt = (uq == '0) ? 1'b0 : msgn_r;
              pc_nxt = P_ADD_T2;
            end
            P_ADD_T2: pc_nxt = P_ADD_SUM;
            P_ADD_D: begin
              ad_nxt = uq; dsn_nxt = msgn_r && uq != '0;
              an_nxt = t1_r; asn_nxt = t1s_r;
              pc_nxt = P_NORM;
            end
            P_MUL_P: begin
              an_nxt = uq; asn_nxt = msgn_r && uq != '0; pc_nxt = P_MUL_Q;
            end
            default: begin
              ad_nxt = uq; dsn_nxt = msgn_r && uq != '0; pc_nxt = P_NORM;
            end
          endcase
          if (pc_r == P_ADD_T2) begin
            st_nxt = S_DCALL; // S_DCALL registers the sum
            ov_valid_nxt = 1'b1;
          end
        end
      end
      S_DCALL: begin
        // mx/msgn now hold t2; sum into t1
        if (sov) bad_nxt = 1'b1;
        t1_nxt = sres; t1s_nxt = sneg;
        pc_nxt = P_ADD_D;
        st_nxt = S_NEXT;
      end
      S_GSTEP: begin
        if (gy_r == '0) begin
          if (gx_r == '0) gx_nxt = {{(W-1){1'b0}}, 1'b1};
          st_nxt = S_DWAIT;
          sub_nxt = 2'd1;
          g1_nxt = (gx_r == '0) ? {{(W-1){1'b0}}, 1'b1} : gx_r;
        end else begin
          ucmd.go = 1'b1; ucmd.uop = UOP_DIV; ux = gx_r; uy = gy_r;
          st_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (udone) begin
          gx_nxt = gy_r; gy_nxt = ur; st_nxt = S_GSTEP;
        end
      end
      S_DWAIT: begin
        // divide both operands of this gcd by it: sub 1 first, 2 second
        case (sub_r)
          2'd1: begin
            ucmd.go = 1'b1; ucmd.uop = UOP_DIV; uy = g1_r;
            ux = (pc_r == P_MUL_G2) ? bn_r : an_r;
            sub_nxt = 2'd2; st_nxt = S_RWAIT;
          end
          default: begin
            ucmd.go = 1'b1; ucmd.uop = UOP_DIV; uy = g1_r;
            ux = (pc_r == P_MUL_G1) ? bd_r : ad_r;
            sub_nxt = 2'd3; st_nxt = S_RWAIT;
          end
        endcase
      end
      S_RWAIT: begin
        if (udone) begin
          if (sub_r == 2'd2) begin
            if (pc_r == P_MUL_G2) bn_nxt = uq; else an_nxt = uq;
            st_nxt = S_DWAIT;
          end else begin
            if (pc_r == P_MUL_G1) bd_nxt = uq; else ad_nxt = uq;
            st_nxt = S_NEXT;
            case (pc_r)
              P_MUL_G1: pc_nxt = P_MUL_G2;
              P_MUL_G2: pc_nxt = P_MUL_P;
              default:  pc_nxt = ((op_r == OP_FLR) || (op_r == OP_CEIL)) ?
                                 P_DONE : P_DONE;
            endcase
            if (pc_r == P_RED && (op_r == OP_FLR || op_r == OP_CEIL))
              st_nxt = S_RND;
          end
        end
      end
      S_RND: begin
        ucmd.go = 1'b1; ucmd.uop = UOP_DIV; ux = an_r; uy = ad_r;
        st_nxt = S_MCALL;
        pc_nxt = P_DONE;
        st_nxt = S_OUT;
        neg_nxt = 1'b1;
      end
      S_OUT: begin
        if (neg_r) begin
          if (udone) begin
            // truncate then step away from zero as needed
            an_nxt = uq + ((ur != '0) && ((asn_r && op_r == OP_FLR) ||
                     (!asn_r && op_r == OP_CEIL)) ? 1'b1 : 1'b0);
            ad_nxt = {{(W-1){1'b0}}, 1'b1};
            neg_nxt = 1'b0;
            if ((uq + ((ur != '0) && ((asn_r && op_r == OP_FLR) ||
                (!asn_r && op_r == OP_CEIL)) ? 1'b1 : 1'b0)) == '0)
              asn_nxt = 1'b0;
          end
        end else begin
          rb_nxt = bad_r;
          if (bad_r) begin
            rn_nxt = '0; rd_nxt = 63'd1;
          end else begin
            rn_nxt = 64'($signed(asn_r ? (~an_r + 1'b1) : an_r));
            rd_nxt = 63'(ad_r);
          end
          st_nxt = S_IDLE;
          ov_valid_nxt = 1'b1;
          bad_nxt = 1'b0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r != S_OUT && st_r != S_MWAIT) ov_valid_nxt = 1'b0;
    if (st_r == S_MWAIT) ov_valid_nxt = 1'b0;
  end

  logic out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_v_r <= 1'b0; neg_r <= 1'b0; bad_r <= 1'b0;
      pc_r <= P_DONE;
    end else begin
      st_r <= st_nxt; out_v_r <= ov_valid_nxt; neg_r <= neg_nxt;
      bad_r <= bad_nxt; pc_r <= pc_nxt;
    end
    op_r <= op_nxt; an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt;
    bd_r <= bd_nxt; asn_r <= asn_nxt; dsn_r <= dsn_nxt; bsn_r <= bsn_nxt;
    bdsn_r <= bdsn_nxt; t1_r <= t1_nxt; t1s_r <= t1s_nxt; gx_r <= gx_nxt;
    gy_r <= gy_nxt; g1_r <= g1_nxt; mx_r <= mx_nxt; my_r <= my_nxt;
    msgn_r <= msgn_nxt; sub_r <= sub_nxt; ov_r <= ov_nxt; rn_r <= rn_nxt;
    rd_r <= rd_nxt; rb_r <= rb_nxt; ov_valid_r <= ov_valid_nxt;
  end

  assign busy            = (st_r != S_IDLE);
  assign out_valid       = out_v_r && ov_valid_r;
  assign out_res_num     = rn_r;
  assign out_res_den     = rd_r;
  assign out_res_bad     = rb_r;
  assign out_is_zero     = !rb_r && rn_r == '0;
  assign out_is_positive = !rb_r && !rn_r[63] && rn_r != '0;
  assign out_is_negative = !rb_r && rn_r[63];
  assign out_is_integer  = !rb_r && rd_r == 63'd1;

  a_valid_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_IDLE)
    else $error("result shown while still busy");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_bad |-> out_res_num == '0 && out_res_den == 63'd1)
    else $error("bad result not 0/1");
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_den != '0)
    else $error("zero denominator delivered");
endmodule
`default_nettype wire

@@ rtl/core/era_unit.sv @@
// era_unit: bit-serial unsigned multiplier (shift-add) and divider
// (restoring), one bit per cycle; uses era_pkg
`default_nettype none
module era_unit #(
  parameter int W = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  era_pkg::ucmd_t     cmd,
  input  wire logic [W-1:0]  x,
  input  wire logic [W-1:0]  y,
  output logic               done,
  output logic [W-1:0]       q_lo,
  output logic [W-1:0]       r_hi
);
  import era_pkg::*;
  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  uop_t          uop_r, uop_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    sum;
  logic [W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    uop_nxt  = uop_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    y_nxt    = y_r;
    done_nxt = 1'b0;
    sum      = {1'b0, acc_r} + {1'b0, y_r};
    trial    = {acc_r, sh_r[W-1]} - {1'b0, y_r};
    if (cmd.go) begin
      busy_nxt = 1'b1;
      uop_nxt  = cmd.uop;
      cnt_nxt  = CW'(W);
      acc_nxt  = '0;
      sh_nxt   = x;
      y_nxt    = y;
    end else if (busy_r) begin
      case (uop_r)
        UOP_MUL: begin
          // product high in acc, low shifts into sh
          if (sh_r[0]) begin
            acc_nxt = sum[W:1];
            sh_nxt  = {sum[0], sh_r[W-1:1]};
          end else begin
            acc_nxt = {1'b0, acc_r[W-1:1]};
            sh_nxt  = {acc_r[0], sh_r[W-1:1]};
          end
        end
        default: begin
          if (!trial[W]) begin
            acc_nxt = trial[W-1:0];
            sh_nxt  = {sh_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = {acc_r[W-2:0], sh_r[W-1]};
            sh_nxt  = {sh_r[W-2:0], 1'b0};
          end
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      uop_r  <= UOP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      uop_r  <= uop_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    y_r   <= y_nxt;
  end

  assign done = done_r;
  assign q_lo = sh_r;
  assign r_hi = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("unit done without work");
  a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !cmd.go |=> !$past(cmd.go) || busy_r)
    else $error("unit lost a command");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && $past(busy_r) |-> cnt_r == '0)
    else $error("unit stopped early");
endmodule
`default_nettype wire
